FILE: sv/mctb_pkg.sv
// Shared types and constants for the multi-channel token bucket.
// No dependencies; used by mctb_ctrl, mctb_dp and the top level.
package mctb_pkg;

    // Number of buckets and derived widths.
    localparam int CHANNELS = 64;
    localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_W     = 6;
    localparam int CMP_W    = 9;
    localparam int TOK_W    = 24;
    localparam int CMD_W    = 2;
    localparam int IDX_W    = 1;

    // Request command codes. The fourth code has no meaning and answers zero.
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK = 2'd0,
        CMD_TAKE = 2'd1,
        CMD_GIVE = 2'd2
    } cmd_t;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_REFILL = 1'b0;
    localparam logic [IDX_W-1:0] REG_BURST  = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_TRD,
        S_TWR
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic exec;
        logic sweep_rd;
        logic sweep_wr;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_last;
    } sts_t;

endpackage

FILE: sv/mctb_ctrl.sv
// Controller state machine for the token bucket block.
// Depends on mctb_pkg for the state type and the command/status structs.
module mctb_ctrl
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [mctb_pkg::CMD_W-1:0]     command,
    input  mctb_pkg::sts_t                 sts,
    output mctb_pkg::ctl_t                 ctl,
    output logic                           busy
);

    mctb_pkg::state_t state_reg;
    mctb_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mctb_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next   = state_reg;
        ctl          = '0;
        busy         = 1'b1;
        case (state_reg)
            mctb_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctl.accept = 1'b1;
                    if (command == mctb_pkg::CMD_TICK)
                    begin
                        state_next = mctb_pkg::S_TRD;
                    end
                    else
                    begin
                        state_next = mctb_pkg::S_EXEC;
                    end
                end
            end
            mctb_pkg::S_EXEC:
            begin
                ctl.exec   = 1'b1;
                state_next = mctb_pkg::S_IDLE;
            end
            mctb_pkg::S_TRD:
            begin
                ctl.sweep_rd = 1'b1;
                state_next   = mctb_pkg::S_TWR;
            end
            mctb_pkg::S_TWR:
            begin
                ctl.sweep_wr = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = mctb_pkg::S_IDLE;
                end
                else
                begin
                    state_next = mctb_pkg::S_TRD;
                end
            end
            default:
            begin
                state_next = mctb_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/mctb_dp.sv
// Datapath for the token bucket block: level memory, valid flags,
// configuration registers, sweep counter and result registers. Uses mctb_pkg.
module mctb_dp
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  mctb_pkg::ctl_t                 ctl,
    output mctb_pkg::sts_t                 sts,
    input  logic [mctb_pkg::CMD_W-1:0]     command,
    input  logic [mctb_pkg::CH_W-1:0]      channel,
    input  logic [mctb_pkg::TOK_W-1:0]     amount,
    input  logic                           wr_en,
    input  logic [mctb_pkg::IDX_W-1:0]     wr_index,
    input  logic [mctb_pkg::TOK_W-1:0]     wr_data,
    output logic                           done,
    output logic [mctb_pkg::TOK_W-1:0]     granted,
    output logic                           empty_res
);

    // Level memory and per-entry valid flags; an entry not yet written reads zero.
    logic [mctb_pkg::TOK_W-1:0]    mem [mctb_pkg::CHANNELS];
    logic [mctb_pkg::CHANNELS-1:0] vld_reg;

    logic [mctb_pkg::TOK_W-1:0]    refill_reg;
    logic [mctb_pkg::TOK_W-1:0]    burst_reg;

    logic [mctb_pkg::CMD_W-1:0]    cmd_reg;
    logic [mctb_pkg::CH_AW-1:0]    addr_reg;
    logic                          chok_reg;
    logic [mctb_pkg::TOK_W-1:0]    amt_reg;
    logic [mctb_pkg::CH_AW-1:0]    cnt_reg;

    logic [mctb_pkg::TOK_W-1:0]    rdata_reg;
    logic                          rvld_reg;

    logic                          done_reg;
    logic                          done_next;
    logic [mctb_pkg::TOK_W-1:0]    granted_reg;
    logic [mctb_pkg::TOK_W-1:0]    granted_next;
    logic                          empty_reg;
    logic                          empty_next;

    logic [mctb_pkg::CMP_W-1:0]    ch_ext;
    logic                          ch_ok;
    logic [mctb_pkg::CH_AW-1:0]    in_addr;
    logic [mctb_pkg::CH_AW-1:0]    rd_addr;
    logic                          rd_en;
    logic [mctb_pkg::CH_AW-1:0]    wr_addr;
    logic                          mem_we;
    logic [mctb_pkg::TOK_W-1:0]    mem_wdata;
    logic [mctb_pkg::TOK_W-1:0]    level;
    logic [mctb_pkg::TOK_W-1:0]    add_val;
    logic [mctb_pkg::TOK_W:0]      sum;
    logic [mctb_pkg::TOK_W-1:0]    capped;
    logic [mctb_pkg::TOK_W-1:0]    grant;

    // Channel range check and memory index of the incoming request.
    assign ch_ext  = mctb_pkg::CMP_W'(channel);
    assign ch_ok   = (ch_ext < mctb_pkg::CMP_W'(mctb_pkg::CHANNELS));
    assign in_addr = ch_ext[mctb_pkg::CH_AW-1:0];

    assign sts.sweep_last = (cnt_reg == mctb_pkg::CH_AW'(mctb_pkg::CHANNELS - 1));

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refill_reg <= '0;
            burst_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                mctb_pkg::REG_REFILL: refill_reg <= wr_data;
                mctb_pkg::REG_BURST:  burst_reg  <= wr_data;
                default:              ;
            endcase
        end
    end

    // Request capture and sweep counter.
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg  <= command;
            addr_reg <= in_addr;
            chok_reg <= ch_ok;
            amt_reg  <= amount;
            cnt_reg  <= '0;
        end
        else if (ctl.sweep_wr)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Read address: the request's channel on accept, the counter during a sweep.
    always_comb
    begin
        rd_addr = ctl.sweep_rd ? cnt_reg : in_addr;
        rd_en   = ctl.sweep_rd || (ctl.accept && ch_ok);
    end

    // Memory read port with registered data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
            rvld_reg  <= vld_reg[rd_addr];
        end
    end

    // Level arithmetic: capped add for tick and give, clamp for take.
    always_comb
    begin
        level   = rvld_reg ? rdata_reg : '0;
        add_val = ctl.sweep_wr ? refill_reg : amt_reg;
        sum     = {1'b0, level} + {1'b0, add_val};
        capped  = (sum > {1'b0, burst_reg}) ? burst_reg : sum[mctb_pkg::TOK_W-1:0];
        grant   = (amt_reg < level) ? amt_reg : level;
    end

    // Write-back and result selection.
    always_comb
    begin
        mem_we       = 1'b0;
        wr_addr      = addr_reg;
        mem_wdata    = capped;
        done_next    = 1'b0;
        granted_next = '0;
        empty_next   = 1'b0;
        if (ctl.sweep_wr)
        begin
            mem_we    = 1'b1;
            wr_addr   = cnt_reg;
            done_next = sts.sweep_last;
        end
        else if (ctl.exec)
        begin
            done_next = 1'b1;
            case (cmd_reg)
                mctb_pkg::CMD_TAKE:
                begin
                    if (!chok_reg || (level == '0))
                    begin
                        empty_next = 1'b1;
                    end
                    else
                    begin
                        granted_next = grant;
                        mem_we       = 1'b1;
                        mem_wdata    = level - grant;
                    end
                end
                mctb_pkg::CMD_GIVE:
                begin
                    mem_we = chok_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Memory write port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= mem_wdata;
        end
    end

    // Valid flags, cleared together at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (mem_we)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // Result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        granted_reg <= granted_next;
        empty_reg   <= empty_next;
    end

    assign done      = done_reg;
    assign granted   = granted_reg;
    assign empty_res = empty_reg;

endmodule

FILE: sv/multi_channel_token_bucket_top.sv
// Take, give and the unused command: accept reads the memory, S_EXEC writes back and
// registers the result strobe, and busy keeps a new request out until that is done.
// Tick: the sweep reads and rewrites one bucket per S_TRD/S_TWR pair, so the result
// comes once all CHANNELS buckets are rewritten and busy stays high until then.
// Reset clears state, configuration and all levels at once through per-bucket
// valid flags; no clearing pass. The receiver cannot stall: done lasts one cycle.
module multi_channel_token_bucket_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [mctb_pkg::CMD_W-1:0]     command,
    input  logic [mctb_pkg::CH_W-1:0]      channel,
    input  logic [mctb_pkg::TOK_W-1:0]     amount,
    input  logic                           wr_en,
    input  logic [mctb_pkg::IDX_W-1:0]     wr_index,
    input  logic [mctb_pkg::TOK_W-1:0]     wr_data,
    output logic                           done,
    output logic [mctb_pkg::TOK_W-1:0]     granted,
    output logic                           empty_res
);

    mctb_pkg::ctl_t ctl;
    mctb_pkg::sts_t sts;

    // Sequencer.
    mctb_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .sts     (sts),
        .ctl     (ctl),
        .busy    (busy)
    );

    // Bucket storage and arithmetic.
    mctb_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .command   (command),
        .channel   (channel),
        .amount    (amount),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .done      (done),
        .granted   (granted),
        .empty_res (empty_res)
    );

endmodule
